// ===== rtl/qpt_pkg.sv =====
// Package for the quaternion point transform.
// Holds register codes, mode codes, datapath widths, the register bank type and
// the rounding and saturation helpers. No dependencies.
package qpt_pkg;

  localparam logic [2:0] CFG_QUAT_X  = 3'd0;
  localparam logic [2:0] CFG_QUAT_Y  = 3'd1;
  localparam logic [2:0] CFG_QUAT_Z  = 3'd2;
  localparam logic [2:0] CFG_QUAT_W  = 3'd3;
  localparam logic [2:0] CFG_SHIFT_X = 3'd4;
  localparam logic [2:0] CFG_SHIFT_Y = 3'd5;
  localparam logic [2:0] CFG_SHIFT_Z = 3'd6;
  localparam logic [2:0] CFG_MODE    = 3'd7;

  localparam logic [1:0] MODE_ROT       = 2'd0;
  localparam logic [1:0] MODE_ROT_SHIFT = 2'd1;
  localparam logic [1:0] MODE_SHIFT_ROT = 2'd2;

  localparam logic signed [15:0] QUAT_W_RESET = 16'sd16384;

  localparam int PW  = 33;
  localparam int P1W = 50;
  localparam int CW  = 37;
  localparam int P2W = 53;
  localparam int UW  = 55;
  localparam int DW  = 42;
  localparam int SW  = 44;

  localparam logic signed [P1W:0]  RND_C = (P1W+1)'(1 << 13);
  localparam logic signed [UW-1:0] RND_D = UW'(1 << 12);
  localparam logic signed [SW-1:0] SAT_HI = SW'(64'sh7FFF_FFFF);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(64'sh8000_0000);

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
    logic [1:0]         mode;
  } cfg_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  function automatic logic signed [CW-1:0] round_c(input logic signed [P1W-1:0] a,
                                                   input logic signed [P1W-1:0] b);
    logic signed [P1W:0] t;
    t = $signed({a[P1W-1], a}) - $signed({b[P1W-1], b}) + RND_C;
    return CW'(t >>> 14);
  endfunction

  function automatic logic signed [DW-1:0] round_d(input logic signed [P2W-1:0] a,
                                                   input logic signed [P2W-1:0] b,
                                                   input logic signed [P2W-1:0] c);
    logic signed [UW-1:0] t;
    t = UW'(a) + UW'(b) - UW'(c) + RND_D;
    return DW'(t >>> 13);
  endfunction

  function automatic sat_t saturate(input logic signed [SW-1:0] v);
    sat_t r;
    r.clip = 1'b0;
    r.val  = v[31:0];
    if (v > SAT_HI) begin
      r.clip = 1'b1;
      r.val  = SAT_HI[31:0];
    end else if (v < SAT_LO) begin
      r.clip = 1'b1;
      r.val  = SAT_LO[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/qpt_regs.sv =====
// Configuration register bank: quaternion, translation and mode.
// Depends on qpt_pkg.
module qpt_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output qpt_pkg::cfg_t  cfg
);
  import qpt_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_QUAT_X:  cfg_nxt.quat_x  = cfg_data[15:0];
        CFG_QUAT_Y:  cfg_nxt.quat_y  = cfg_data[15:0];
        CFG_QUAT_Z:  cfg_nxt.quat_z  = cfg_data[15:0];
        CFG_QUAT_W:  cfg_nxt.quat_w  = cfg_data[15:0];
        CFG_SHIFT_X: cfg_nxt.shift_x = cfg_data;
        CFG_SHIFT_Y: cfg_nxt.shift_y = cfg_data;
        CFG_SHIFT_Z: cfg_nxt.shift_z = cfg_data;
        CFG_MODE:    cfg_nxt.mode    = cfg_data[1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quat_x  <= '0;
      cfg_r.quat_y  <= '0;
      cfg_r.quat_z  <= '0;
      cfg_r.quat_w  <= QUAT_W_RESET;
      cfg_r.shift_x <= '0;
      cfg_r.shift_y <= '0;
      cfg_r.shift_z <= '0;
      cfg_r.mode    <= MODE_ROT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/qpt_rotate.sv =====
// Four-stage rotation datapath: cross products, round, second products, round.
// Yields the rotation offset and the delayed point. Depends on qpt_pkg.
module qpt_rotate (
  input  logic                           clk,
  input  logic                           rst_n,
  input  qpt_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  input  logic signed [qpt_pkg::PW-1:0]  in_px,
  input  logic signed [qpt_pkg::PW-1:0]  in_py,
  input  logic signed [qpt_pkg::PW-1:0]  in_pz,
  output logic                           out_valid,
  output logic signed [qpt_pkg::PW-1:0]  out_px,
  output logic signed [qpt_pkg::PW-1:0]  out_py,
  output logic signed [qpt_pkg::PW-1:0]  out_pz,
  output logic signed [qpt_pkg::DW-1:0]  out_dx,
  output logic signed [qpt_pkg::DW-1:0]  out_dy,
  output logic signed [qpt_pkg::DW-1:0]  out_dz
);
  import qpt_pkg::*;

  logic [3:0] vld_r, vld_nxt;

  logic signed [PW-1:0] p1x_r, p1y_r, p1z_r;
  logic signed [PW-1:0] p2x_r, p2y_r, p2z_r;
  logic signed [PW-1:0] p3x_r, p3y_r, p3z_r;
  logic signed [PW-1:0] p4x_r, p4y_r, p4z_r;

  logic signed [P1W-1:0] ayz_r, azy_r, azx_r, axz_r, axy_r, ayx_r;
  logic signed [CW-1:0]  cx_r, cy_r, cz_r;
  logic signed [P2W-1:0] wcx_r, wcy_r, wcz_r;
  logic signed [P2W-1:0] bycz_r, bzcy_r, bzcx_r, bxcz_r, bxcy_r, bycx_r;
  logic signed [DW-1:0]  dx_r, dy_r, dz_r;

  assign vld_nxt = {vld_r[2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    // first cross product
    ayz_r <= cfg.quat_y * in_pz;
    azy_r <= cfg.quat_z * in_py;
    azx_r <= cfg.quat_z * in_px;
    axz_r <= cfg.quat_x * in_pz;
    axy_r <= cfg.quat_x * in_py;
    ayx_r <= cfg.quat_y * in_px;
    p1x_r <= in_px;
    p1y_r <= in_py;
    p1z_r <= in_pz;
    // round to Q16.16
    cx_r  <= round_c(ayz_r, azy_r);
    cy_r  <= round_c(azx_r, axz_r);
    cz_r  <= round_c(axy_r, ayx_r);
    p2x_r <= p1x_r;
    p2y_r <= p1y_r;
    p2z_r <= p1z_r;
    // scalar term and second cross product
    wcx_r  <= cfg.quat_w * cx_r;
    wcy_r  <= cfg.quat_w * cy_r;
    wcz_r  <= cfg.quat_w * cz_r;
    bycz_r <= cfg.quat_y * cz_r;
    bzcy_r <= cfg.quat_z * cy_r;
    bzcx_r <= cfg.quat_z * cx_r;
    bxcz_r <= cfg.quat_x * cz_r;
    bxcy_r <= cfg.quat_x * cy_r;
    bycx_r <= cfg.quat_y * cx_r;
    p3x_r  <= p2x_r;
    p3y_r  <= p2y_r;
    p3z_r  <= p2z_r;
    // sum and round the doubled offset
    dx_r  <= round_d(wcx_r, bycz_r, bzcy_r);
    dy_r  <= round_d(wcy_r, bzcx_r, bxcz_r);
    dz_r  <= round_d(wcz_r, bxcy_r, bycx_r);
    p4x_r <= p3x_r;
    p4y_r <= p3y_r;
    p4z_r <= p3z_r;
  end

  assign out_valid = vld_r[3];
  assign out_px    = p4x_r;
  assign out_py    = p4y_r;
  assign out_pz    = p4z_r;
  assign out_dx    = dx_r;
  assign out_dy    = dy_r;
  assign out_dz    = dz_r;

endmodule

// ===== rtl/quaternion_point_transform.sv =====
// Quaternion point transform: rotates Q16.16 points by a Q1.14 quaternion, with optional translation.
// Takes one word per cycle from start; busy stays low.
// Six register stages: pre-translate, cross products, round, products, round, sum.
// Synchronous active-low reset clears the pipeline valid bits and sets the
// registers to identity rotation, zero translation, rotate-only mode.
module quaternion_point_transform (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_clipped,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import qpt_pkg::*;

  cfg_t cfg;

  logic                 s0_vld_r;
  logic signed [PW-1:0] s0_px_r, s0_py_r, s0_pz_r;
  logic signed [PW-1:0] s0_px_nxt, s0_py_nxt, s0_pz_nxt;

  logic                 rot_vld;
  logic signed [PW-1:0] rot_px, rot_py, rot_pz;
  logic signed [DW-1:0] rot_dx, rot_dy, rot_dz;

  logic signed [SW-1:0] sum_x, sum_y, sum_z;
  sat_t                 sat_x, sat_y, sat_z;

  logic                 out_vld_r;
  logic signed [31:0]   out_x_r, out_y_r, out_z_r;
  logic                 out_clip_r;

  qpt_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign busy = 1'b0;

  always_comb begin
    s0_px_nxt = PW'(in_point_x);
    s0_py_nxt = PW'(in_point_y);
    s0_pz_nxt = PW'(in_point_z);
    if (cfg.mode == MODE_SHIFT_ROT) begin
      s0_px_nxt = PW'(in_point_x) + PW'(cfg.shift_x);
      s0_py_nxt = PW'(in_point_y) + PW'(cfg.shift_y);
      s0_pz_nxt = PW'(in_point_z) + PW'(cfg.shift_z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s0_vld_r  <= start & ~busy;
      out_vld_r <= rot_vld;
    end
  end

  always_ff @(posedge clk) begin
    s0_px_r <= s0_px_nxt;
    s0_py_r <= s0_py_nxt;
    s0_pz_r <= s0_pz_nxt;
  end

  qpt_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (s0_vld_r),
    .in_px     (s0_px_r),
    .in_py     (s0_py_r),
    .in_pz     (s0_pz_r),
    .out_valid (rot_vld),
    .out_px    (rot_px),
    .out_py    (rot_py),
    .out_pz    (rot_pz),
    .out_dx    (rot_dx),
    .out_dy    (rot_dy),
    .out_dz    (rot_dz)
  );

  always_comb begin
    sum_x = SW'(rot_px) + SW'(rot_dx);
    sum_y = SW'(rot_py) + SW'(rot_dy);
    sum_z = SW'(rot_pz) + SW'(rot_dz);
    if (cfg.mode == MODE_ROT_SHIFT) begin
      sum_x = sum_x + SW'(cfg.shift_x);
      sum_y = sum_y + SW'(cfg.shift_y);
      sum_z = sum_z + SW'(cfg.shift_z);
    end
    sat_x = saturate(sum_x);
    sat_y = saturate(sum_y);
    sat_z = saturate(sum_z);
  end

  always_ff @(posedge clk) begin
    out_x_r    <= sat_x.val;
    out_y_r    <= sat_y.val;
    out_z_r    <= sat_z.val;
    out_clip_r <= sat_x.clip | sat_y.clip | sat_z.clip;
  end

  assign out_valid   = out_vld_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_z       = out_z_r;
  assign out_clipped = out_clip_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##6 out_valid)
    else $error("accepted word did not emerge after six cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 6))
    else $error("result word without a matching start");

  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_x == 32'sh7FFF_FFFF || out_x == 32'sh8000_0000 ||
       out_y == 32'sh7FFF_FFFF || out_y == 32'sh8000_0000 ||
       out_z == 32'sh7FFF_FFFF || out_z == 32'sh8000_0000))
    else $error("clip flagged but no coordinate at a rail");
`endif

endmodule
